[sv/sppm_pkg.sv]
// Shared types, constants and register indexes for the stop pulse period monitor.
`timescale 1ns / 1ps

package sppm_pkg;

    // Free-running capture timer width, and the width of the captured value
    localparam int TIMER_BITS = 16;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISSED_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRONG_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [LIMIT_W-1:0] RST_BOUNCE_LIMIT = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_PERIOD_LOW   = 16'd56500;
    localparam logic [LIMIT_W-1:0] RST_PERIOD_HIGH  = 16'd61500;
    localparam logic [COUNT_W-1:0] RST_MISSED_LIMIT = 4'd3;
    localparam logic [COUNT_W-1:0] RST_WRONG_LIMIT  = 4'd5;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Fail codes on the result
    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_MISSING = 2'd1;
    localparam logic [1:0] FAIL_WRONG   = 2'd2;

    typedef struct packed {
        logic [LIMIT_W-1:0] bounce_limit;
        logic [LIMIT_W-1:0] period_low;
        logic [LIMIT_W-1:0] period_high;
        logic [COUNT_W-1:0] missed_limit;
        logic [COUNT_W-1:0] wrong_limit;
    } t_cfg;

    typedef struct packed {
        logic                  op;
        logic                  stop_released;
        logic                  capture_valid;
        logic [TIMER_BITS-1:0] capture_value;
    } t_item;

    typedef struct packed {
        logic [1:0] fail_code;
        logic       missing_flag;
        logic       wrong_flag;
    } t_result;

endpackage

[sv/stop_pulse_period_monitor.sv]
// Top level of the stop pulse period monitor: input register, evaluation, result register.
// An item passes through the input register and then the result register.
// Throughput: one item per cycle while i_out_stall is low; the evaluation of the item in the
// input register is combinational, and the state updates as the item enters the result register.
// Reset (i_rst_n low, synchronous): both stages empty, counts, flags and last capture
// cleared, configuration registers back to their defaults. No clearing pass.
`timescale 1ns / 1ps

module stop_pulse_period_monitor
    import sppm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic                  i_stop_released,
    input  logic                  i_capture_valid,
    input  logic [TIMER_BITS-1:0] i_capture_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_fail_code,
    output logic                  o_missing_flag,
    output logic                  o_wrong_flag,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    advance;
    logic    in_xfer;

    sppm_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sppm_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Item moves to the result register when that register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.op            <= i_op;
            r_in.stop_released <= i_stop_released;
            r_in.capture_valid <= i_capture_valid;
            r_in.capture_value <= i_capture_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fail_code    = r_out.fail_code;
    assign o_missing_flag = r_out.missing_flag;
    assign o_wrong_flag   = r_out.wrong_flag;

endmodule

[sv/sppm_cfg_regs.sv]
// Configuration register file of the stop pulse period monitor.
`timescale 1ns / 1ps

module sppm_cfg_regs
    import sppm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounce_limit <= RST_BOUNCE_LIMIT;
            r_cfg.period_low   <= RST_PERIOD_LOW;
            r_cfg.period_high  <= RST_PERIOD_HIGH;
            r_cfg.missed_limit <= RST_MISSED_LIMIT;
            r_cfg.wrong_limit  <= RST_WRONG_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOUNCE_LIMIT: r_cfg.bounce_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_PERIOD_LOW:   r_cfg.period_low   <= i_cfg_data[LIMIT_W-1:0];
                REG_PERIOD_HIGH:  r_cfg.period_high  <= i_cfg_data[LIMIT_W-1:0];
                REG_MISSED_LIMIT: r_cfg.missed_limit <= i_cfg_data[COUNT_W-1:0];
                REG_WRONG_LIMIT:  r_cfg.wrong_limit  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/sppm_eval.sv]
// Monitor state and per-item evaluation: counts, period check and flags.
`timescale 1ns / 1ps

module sppm_eval
    import sppm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [TIMER_BITS-1:0] r_last_capture, n_last_capture;
    logic [COUNT_W-1:0]    r_overflow_count, n_overflow_count;
    logic [COUNT_W-1:0]    r_wrong_count, n_wrong_count;
    logic                  r_missing, n_missing;
    logic                  r_wrong, n_wrong;

    logic [TIMER_BITS-1:0] period;
    logic [COUNT_W-1:0]    wc_poll;
    logic                  bad_period;

    // Period since the previous capture, wrapping with the timer
    assign period = i_item.capture_value - r_last_capture;

    assign bad_period = (period == '0) || (r_overflow_count > COUNT_W'(1))
                     || ((period > i_cfg.bounce_limit) && (period < i_cfg.period_low))
                     || (period > i_cfg.period_high);

    // A pressed switch clears the wrong count before the capture is judged
    assign wc_poll = i_item.stop_released ? r_wrong_count : '0;

    // Next state for the item in the input register
    always_comb begin
        n_last_capture   = r_last_capture;
        n_overflow_count = r_overflow_count;
        n_wrong_count    = r_wrong_count;
        n_missing        = r_missing;
        n_wrong          = r_wrong;
        if (i_item.op == OP_TICK) begin
            if (i_item.stop_released && (r_overflow_count < i_cfg.missed_limit)) begin
                n_overflow_count = r_overflow_count + COUNT_W'(1);
            end
        end else begin
            n_wrong_count = wc_poll;
            if (i_item.capture_valid) begin
                n_last_capture = i_item.capture_value;
                if (bad_period) begin
                    if (wc_poll < i_cfg.wrong_limit) begin
                        n_wrong_count = wc_poll + COUNT_W'(1);
                    end
                end else begin
                    n_wrong_count = '0;
                end
                n_overflow_count = '0;
            end
            n_wrong   = (n_wrong_count >= i_cfg.wrong_limit);
            n_missing = (n_overflow_count >= i_cfg.missed_limit);
        end
    end

    // State update on each move from the input register to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture   <= '0;
            r_overflow_count <= '0;
            r_wrong_count    <= '0;
            r_missing        <= 1'b0;
            r_wrong          <= 1'b0;
        end else if (i_fire) begin
            r_last_capture   <= n_last_capture;
            r_overflow_count <= n_overflow_count;
            r_wrong_count    <= n_wrong_count;
            r_missing        <= n_missing;
            r_wrong          <= n_wrong;
        end
    end

    // Result from the flags after this item; missing wins over wrong
    always_comb begin
        o_result.missing_flag = n_missing;
        o_result.wrong_flag   = n_wrong;
        if (n_missing) begin
            o_result.fail_code = FAIL_MISSING;
        end else if (n_wrong) begin
            o_result.fail_code = FAIL_WRONG;
        end else begin
            o_result.fail_code = FAIL_NONE;
        end
    end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the stop pulse period monitor: directed pulses, then random trains.
`timescale 1ns / 1ps

module tb_top;
    import sppm_pkg::*;

    localparam int  RX_HOLD_CYCLES = 64;
    localparam int  PHASES         = 9;
    localparam int  PHASE_ITEMS    = 216;

    // Mirror of the monitor: configuration, counts and flags, plus the
    // flags still owed by the block in transfer order.
    class pulse_monitor_sb;
        logic [LIMIT_W-1:0]    bounce_lim, period_lo, period_hi;
        logic [COUNT_W-1:0]    missed_lim, wrong_lim;
        logic [TIMER_BITS-1:0] last_cap;
        logic [COUNT_W-1:0]    ovf_cnt, wrong_cnt;
        logic                  missing_st, wrong_st;
        t_result               flags_due[$];
        int unsigned           errors;

        function new();
            bounce_lim = RST_BOUNCE_LIMIT;
            period_lo  = RST_PERIOD_LOW;
            period_hi  = RST_PERIOD_HIGH;
            missed_lim = RST_MISSED_LIMIT;
            wrong_lim  = RST_WRONG_LIMIT;
            last_cap   = '0;
            ovf_cnt    = '0;
            wrong_cnt  = '0;
            missing_st = 1'b0;
            wrong_st   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BOUNCE_LIMIT: bounce_lim = data;
                REG_PERIOD_LOW:   period_lo  = data;
                REG_PERIOD_HIGH:  period_hi  = data;
                REG_MISSED_LIMIT: missed_lim = data[COUNT_W-1:0];
                REG_WRONG_LIMIT:  wrong_lim  = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the state by one accepted input transfer and queue its flags
        function void take_item(t_item it);
            logic [TIMER_BITS-1:0] period;
            t_result               flags;
            if (it.op == OP_TICK) begin
                if (it.stop_released && ovf_cnt < missed_lim)
                    ovf_cnt = ovf_cnt + 1'b1;
            end else begin
                if (!it.stop_released)
                    wrong_cnt = '0;
                if (it.capture_valid) begin
                    period   = it.capture_value - last_cap;
                    last_cap = it.capture_value;
                    if (period == '0 || ovf_cnt > 1 ||
                        (period > bounce_lim && period < period_lo) ||
                        period > period_hi) begin
                        if (wrong_cnt < wrong_lim)
                            wrong_cnt = wrong_cnt + 1'b1;
                    end else begin
                        wrong_cnt = '0;
                    end
                    ovf_cnt = '0;
                end
                wrong_st   = (wrong_cnt >= wrong_lim);
                missing_st = (ovf_cnt >= missed_lim);
            end
            flags.fail_code    = missing_st ? FAIL_MISSING : (wrong_st ? FAIL_WRONG : FAIL_NONE);
            flags.missing_flag = missing_st;
            flags.wrong_flag   = wrong_st;
            flags_due.push_back(flags);
        endfunction

        function void report(string what, int want, int got);
            errors++;
            $error("%s: expected %0d, actual %0d", what, want, got);
        endfunction

        // Compare one result transfer with the oldest owed flags
        function void check_flags(t_result got);
            t_result want;
            if (flags_due.size() == 0) begin
                report("unexpected result transfer, fail_code", -1, got.fail_code);
                return;
            end
            want = flags_due.pop_front();
            if (got.fail_code !== want.fail_code)
                report("fail_code", want.fail_code, got.fail_code);
            if (got.missing_flag !== want.missing_flag)
                report("missing_flag", want.missing_flag, got.missing_flag);
            if (got.wrong_flag !== want.wrong_flag)
                report("wrong_flag", want.wrong_flag, got.wrong_flag);
        endfunction

        function int pending();
            return flags_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic                  i_stop_released;
    logic                  i_capture_valid;
    logic [TIMER_BITS-1:0] i_capture_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_fail_code;
    logic                  o_missing_flag;
    logic                  o_wrong_flag;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pulse_monitor_sb       sb;
    t_item                 seen_item;
    t_result               seen_flags;
    logic [TIMER_BITS-1:0] stamp;
    bit                    steady;
    bit                    rx_hold;

    stop_pulse_period_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_stop_released (i_stop_released),
        .i_capture_valid (i_capture_valid),
        .i_capture_value (i_capture_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fail_code     (o_fail_code),
        .o_missing_flag  (o_missing_flag),
        .o_wrong_flag    (o_wrong_flag),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    assign seen_item  = {i_op, i_stop_released, i_capture_valid, i_capture_value};
    assign seen_flags = {o_fail_code, o_missing_flag, o_wrong_flag};

    // Watch both channels and the config port at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.take_item(seen_item);
            if (o_out_valid && !i_out_stall)
                sb.check_flags(seen_flags);
        end
    end

    // Result side: random stall pattern, a long hold-off on request
    initial begin : rx_side
        int unsigned r;
        int unsigned len;
        logic        stall_v;
        forever begin
            r = $urandom_range(0, 99);
            if (rx_hold) begin
                stall_v = 1'b1;
                len     = RX_HOLD_CYCLES;
                rx_hold = 1'b0;
            end else if (steady || r < 55) begin
                stall_v = 1'b0;
                len     = $urandom_range(1, 8);
            end else if (r < 90) begin
                stall_v = 1'b1;
                len     = $urandom_range(1, 3);
            end else begin
                stall_v = 1'b1;
                len     = $urandom_range(10, 40);
            end
            i_out_stall <= stall_v;
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned tx_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_item mk_item(logic op, logic rel, logic cv, logic [TIMER_BITS-1:0] val);
        t_item it;
        it.op            = op;
        it.stop_released = rel;
        it.capture_valid = cv;
        it.capture_value = val;
        return it;
    endfunction

    // Period relative to the current window, biased toward the decision edges
    function automatic logic [TIMER_BITS-1:0] pick_period();
        int unsigned           r;
        logic [TIMER_BITS-1:0] edges[6];
        r = $urandom_range(0, 99);
        edges[0] = sb.bounce_lim;
        edges[1] = sb.bounce_lim + 1'b1;
        edges[2] = sb.period_lo - 1'b1;
        edges[3] = sb.period_lo;
        edges[4] = sb.period_hi;
        edges[5] = sb.period_hi + 1'b1;
        if (r < 50) return 16'($urandom_range(sb.period_lo, sb.period_hi));
        if (r < 62) return 16'($urandom_range(0, sb.bounce_lim));
        if (r < 72) return 16'($urandom_range(sb.bounce_lim, sb.period_lo));
        if (r < 82) return 16'($urandom_range(sb.period_hi, 16'hFFFF));
        if (r < 87) return '0;
        if (r < 94) return edges[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    // One input transfer, then a random gap
    task automatic offer(input t_item it);
        int unsigned gap;
        i_in_valid      <= 1'b1;
        i_op            <= it.op;
        i_stop_released <= it.stop_released;
        i_capture_valid <= it.capture_valid;
        i_capture_value <= it.capture_value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic capture_at(input logic rel, input logic [TIMER_BITS-1:0] val);
        stamp = val;
        offer(mk_item(OP_POLL, rel, 1'b1, val));
    endtask

    task automatic capture_after(input logic rel, input logic [TIMER_BITS-1:0] delta);
        capture_at(rel, stamp + delta);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Rewrite all five registers; the count limits carry junk in the unused bits
    task automatic set_limits(input logic [LIMIT_W-1:0] b, input logic [LIMIT_W-1:0] lo,
                              input logic [LIMIT_W-1:0] hi, input logic [COUNT_W-1:0] ml,
                              input logic [COUNT_W-1:0] wl);
        put_reg(REG_BOUNCE_LIMIT, b);
        put_reg(REG_PERIOD_LOW, lo);
        put_reg(REG_PERIOD_HIGH, hi);
        put_reg(REG_MISSED_LIMIT, {12'($urandom), ml});
        put_reg(REG_WRONG_LIMIT, {12'($urandom), wl});
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed pulse trains: polls with captures, overflow ticks,
    // dropouts, switch presses, with some raw noise mixed in
    task automatic run_pulse_train(input int n);
        int          sent;
        int unsigned r;
        int unsigned burst;
        t_item       it;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                it = mk_item(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
                if (it.op == OP_POLL && it.capture_valid)
                    stamp = it.capture_value;
                offer(it);
                sent++;
            end else if (r < 42) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 16) : 1;
                repeat (burst) begin
                    offer(mk_item(OP_TICK, $urandom_range(0, 9) != 0, 1'($urandom),
                                  16'($urandom)));
                    sent++;
                end
            end else if (r < 50) begin
                offer(mk_item(OP_POLL, $urandom_range(0, 7) != 0, 1'b0, 16'($urandom)));
                sent++;
            end else begin
                capture_after($urandom_range(0, 9) != 0, pick_period());
                sent++;
            end
        end
    endtask

    initial begin
        int          ph;
        int unsigned b, lo, hi;
        sb              = new();
        stamp           = '0;
        steady          = 1'b0;
        rx_hold         = 1'b0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_op            <= OP_TICK;
        i_stop_released <= 1'b0;
        i_capture_valid <= 1'b0;
        i_capture_value <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_BOUNCE_LIMIT;
        i_cfg_data      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default window, boundaries, wrap-around, saturation
        capture_at(1'b1, 16'd60000);
        repeat (4) offer(mk_item(OP_TICK, 1'b1, 1'b0, 16'h0000));
        offer(mk_item(OP_TICK, 1'b0, 1'b1, 16'hFFFF));       // pressed: no count
        offer(mk_item(OP_POLL, 1'b1, 1'b0, 16'hFFFF));       // pulses missing
        capture_after(1'b1, 16'd59000);                       // good period, too many overflows
        capture_after(1'b1, 16'd0);                           // zero period
        capture_after(1'b1, RST_BOUNCE_LIMIT);                // bounce, at the limit
        capture_after(1'b1, RST_BOUNCE_LIMIT + 16'd1);        // short
        capture_after(1'b1, RST_PERIOD_LOW);
        capture_after(1'b1, RST_PERIOD_HIGH);
        capture_after(1'b1, RST_PERIOD_HIGH + 16'd1);         // long
        capture_after(1'b1, 16'hFFFF);
        capture_at(1'b1, 16'h0000);
        capture_at(1'b1, 16'hFFFF);
        capture_after(1'b1, 16'd0);                           // wrong flag sets
        capture_after(1'b1, 16'd0);                           // wrong count saturates
        repeat (3) offer(mk_item(OP_TICK, 1'b1, 1'b0, 16'h0000));
        wait_results_done();

        // Limits lowered below the running counts
        set_limits(RST_BOUNCE_LIMIT, RST_PERIOD_LOW, RST_PERIOD_HIGH, 4'd1, 4'd2);
        offer(mk_item(OP_TICK, 1'b1, 1'b0, 16'h0000));
        offer(mk_item(OP_POLL, 1'b1, 1'b0, 16'h0000));
        capture_after(1'b1, 16'd0);
        offer(mk_item(OP_POLL, 1'b0, 1'b0, 16'h0000));       // press clears wrong count
        wait_results_done();

        // Zero limits keep both flags set
        set_limits(RST_BOUNCE_LIMIT, RST_PERIOD_LOW, RST_PERIOD_HIGH, 4'd0, 4'd0);
        offer(mk_item(OP_TICK, 1'b1, 1'b0, 16'h0000));
        offer(mk_item(OP_POLL, 1'b0, 1'b0, 16'h0000));
        wait_results_done();

        // Random phases, each with its own window and limits
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_limits(RST_BOUNCE_LIMIT, RST_PERIOD_LOW, RST_PERIOD_HIGH,
                              RST_MISSED_LIMIT, RST_WRONG_LIMIT);
                1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
                2: set_limits(16'h0000, 16'h0000, 16'h0000, 4'd0, 4'd0);
                3: set_limits(16'h0000, 16'h0001, 16'hFFFE, 4'd1, 4'd1);
                default: begin
                    if (ph % 2 == 1) begin
                        b  = $urandom_range(0, 9000);
                        lo = $urandom_range(b, 60000);
                        hi = $urandom_range(lo, 65535);
                        set_limits(16'(b), 16'(lo), 16'(hi), 4'($urandom_range(1, 6)),
                                   4'($urandom_range(1, 8)));
                    end else begin
                        set_limits(16'($urandom), 16'($urandom), 16'($urandom),
                                   4'($urandom), 4'($urandom));
                    end
                end
            endcase
            if (ph == 4) begin
                // receiver holds off while items keep coming: input backs up
                steady  = 1'b1;
                rx_hold = 1'b1;
                run_pulse_train(80);
                steady  = 1'b0;
                run_pulse_train(PHASE_ITEMS - 80);
            end else if (ph == 5) begin
                steady = 1'b1;
                run_pulse_train(PHASE_ITEMS / 2);
                steady = 1'b0;
                run_pulse_train(PHASE_ITEMS / 2);
            end else begin
                run_pulse_train(PHASE_ITEMS);
            end
            wait_results_done();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
